// ----- rtl/core/lao_pkg.sv -----
package lao_pkg;

  // Q14 vector component and three-axis vector
  typedef logic signed [15:0] q14_t;

  typedef struct packed {
    q14_t x;
    q14_t y;
    q14_t z;
  } vec3_t;

  // everything that rides along with an item down the pipe
  typedef struct packed {
    vec3_t hp;
    vec3_t hb;
    vec3_t f;
    vec3_t r;
    vec3_t u;
    logic  backup;
  } pipe_t;

  // components fed to a normalizer (covers raw quaternion terms up to 2^36)
  localparam int NW = 38;
  typedef logic signed [NW-1:0] nval_t;

  localparam int ONE = 16384;

  // normalizer: magnitudes brought to [2^29, 2^30)
  localparam int NORM_TOP = 29;
  localparam int NORM_MW  = 30;
  localparam int POS_W    = $clog2(NW);

  // shared square root and divider shapes
  localparam int RAD_W      = 64;
  localparam int ROOT_W     = 32;
  localparam int SQRT_LAT   = ROOT_W;
  localparam int DIV_NUM_W  = 58;
  localparam int DIV_DEN_W  = 31;
  localparam int DIV_QUO_W  = 36;
  localparam int DIV_LAT    = DIV_QUO_W;

  // squared-length thresholds for short right (Q52) and short up (Q56)
  localparam int LEN_W = 62;
  localparam logic [LEN_W-1:0] EPS_RIGHT = LEN_W'(45035996);
  localparam logic [LEN_W-1:0] EPS_UP    = LEN_W'(720575940);

endpackage

// ----- rtl/core/lao_isqrt.sv -----
module lao_isqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [lao_pkg::RAD_W-1:0]    rad,
  output logic [lao_pkg::ROOT_W-1:0]   root
);
  import lao_pkg::*;

  localparam int TW = RAD_W + 2;

  logic [RAD_W-1:0]  rem [ROOT_W];
  logic [ROOT_W-1:0] rt  [ROOT_W];

  // one root bit per stage, remainder kept as rad - root^2
  for (genvar i = 0; i < ROOT_W; i++) begin : g_bit
    localparam int B = ROOT_W - 1 - i;
    logic [RAD_W-1:0]  cur_rem;
    logic [ROOT_W-1:0] cur_rt;
    logic [TW-1:0]     trial;
    logic              fit;

    if (i == 0) begin : g_first
      assign cur_rem = rad;
      assign cur_rt  = '0;
    end else begin : g_next
      assign cur_rem = rem[i-1];
      assign cur_rt  = rt[i-1];
    end

    always_comb begin
      trial = (TW'(cur_rt) << (B + 1)) + (TW'(1) << (2 * B));
      fit   = TW'(cur_rem) >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= fit ? cur_rem - trial[RAD_W-1:0] : cur_rem;
        rt[i]  <= fit ? (cur_rt | (ROOT_W'(1) << B)) : cur_rt;
      end
    end
  end

  assign root = rt[ROOT_W-1];

endmodule

// ----- rtl/core/lao_div.sv -----
module lao_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [lao_pkg::DIV_NUM_W-1:0]   num,
  input  logic [lao_pkg::DIV_DEN_W-1:0]   den,
  output logic [lao_pkg::DIV_QUO_W-1:0]   quo
);
  import lao_pkg::*;

  localparam int HI_W = DIV_NUM_W - DIV_QUO_W;

  logic [DIV_DEN_W-1:0] rem [DIV_QUO_W];
  logic [DIV_QUO_W-1:0] qt  [DIV_QUO_W];
  logic [DIV_QUO_W-1:0] lo  [DIV_QUO_W];
  logic [DIV_DEN_W-1:0] dn  [DIV_QUO_W];

  // restoring division, one quotient bit per stage
  for (genvar i = 0; i < DIV_QUO_W; i++) begin : g_bit
    localparam int B = DIV_QUO_W - 1 - i;
    logic [DIV_DEN_W-1:0] cur_rem;
    logic [DIV_QUO_W-1:0] cur_qt;
    logic [DIV_QUO_W-1:0] cur_lo;
    logic [DIV_DEN_W-1:0] cur_dn;
    logic [DIV_DEN_W:0]   t;
    logic                 fit;

    if (i == 0) begin : g_first
      assign cur_rem = DIV_DEN_W'(num[DIV_NUM_W-1 -: HI_W]);
      assign cur_qt  = '0;
      assign cur_lo  = num[DIV_QUO_W-1:0];
      assign cur_dn  = den;
    end else begin : g_next
      assign cur_rem = rem[i-1];
      assign cur_qt  = qt[i-1];
      assign cur_lo  = lo[i-1];
      assign cur_dn  = dn[i-1];
    end

    always_comb begin
      t   = {cur_rem, cur_lo[B]};
      fit = t >= {1'b0, cur_dn};
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= fit ? DIV_DEN_W'(t - {1'b0, cur_dn}) : DIV_DEN_W'(t);
        qt[i]  <= fit ? (cur_qt | (DIV_QUO_W'(1) << B)) : cur_qt;
        lo[i]  <= cur_lo;
        dn[i]  <= cur_dn;
      end
    end
  end

  assign quo = qt[DIV_QUO_W-1];

endmodule

// ----- rtl/core/lao_norm.sv -----
module lao_norm (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  lao_pkg::nval_t   vec [4],
  input  lao_pkg::pipe_t   in_side,
  output logic             out_valid,
  output lao_pkg::q14_t    unit [4],
  output lao_pkg::pipe_t   out_side
);
  import lao_pkg::*;

  typedef struct packed {
    logic                         vld;
    logic [3:0]                   sgn;
    logic [3:0][NORM_MW-1:0]      mag;
    pipe_t                        side;
  } sq_dly_t;

  typedef struct packed {
    logic       vld;
    logic [3:0] sgn;
    pipe_t      side;
  } dv_dly_t;

  logic              v1, v2, v3, v4, v5, v6;
  logic [NW-1:0]     mag1 [4];
  logic [NW-1:0]     mag2 [4];
  logic [3:0]        sgn1, sgn2, sgn3, sgn4, sgn5, sgn6;
  pipe_t             side1, side2, side3, side4, side5, side6;
  logic [POS_W-1:0]  pos, p2;
  logic [NW-1:0]     orv;
  logic [NW-1:0]     sh [4];
  logic [NORM_MW-1:0] m3 [4];
  logic [NORM_MW-1:0] m4 [4];
  logic [3:0][NORM_MW-1:0] m5;
  logic [2*NORM_MW-1:0] sq4 [4];
  logic [LEN_W-1:0]  sum5;
  logic [ROOT_W-1:0] root;
  sq_dly_t           sdly [SQRT_LAT];
  logic [DIV_NUM_W-1:0] num6 [4];
  logic [DIV_DEN_W-1:0] den6;
  logic [DIV_QUO_W-1:0] quo [4];
  dv_dly_t           ddly [DIV_LAT];
  logic [14:0]       clm [4];

  // stage 1: magnitudes and signs
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1    <= in_valid;
      side1 <= in_side;
      for (int i = 0; i < 4; i++) begin
        mag1[i] <= vec[i][NW-1] ? NW'(-vec[i]) : NW'(vec[i]);
        sgn1[i] <= vec[i][NW-1];
      end
    end
  end

  // stage 2: leading one of the largest magnitude
  always_comb begin
    orv = mag1[0] | mag1[1] | mag1[2] | mag1[3];
    pos = '0;
    for (int j = 0; j < NW; j++) begin
      if (orv[j]) pos = POS_W'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2    <= v1;
      p2    <= pos;
      mag2  <= mag1;
      sgn2  <= sgn1;
      side2 <= side1;
    end
  end

  // stage 3: scale so the top bit sits at NORM_TOP
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (p2 >= POS_W'(NORM_TOP)) sh[i] = mag2[i] >> (p2 - POS_W'(NORM_TOP));
      else sh[i] = mag2[i] << (POS_W'(NORM_TOP) - p2);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3    <= v2;
      sgn3  <= sgn2;
      side3 <= side2;
      for (int i = 0; i < 4; i++) m3[i] <= sh[i][NORM_MW-1:0];
    end
  end

  // stage 4: squares
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4    <= v3;
      sgn4  <= sgn3;
      side4 <= side3;
      m4    <= m3;
      for (int i = 0; i < 4; i++) sq4[i] <= m3[i] * m3[i];
    end
  end

  // stage 5: squared length
  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5    <= v4;
      sgn5  <= sgn4;
      side5 <= side4;
      for (int i = 0; i < 4; i++) m5[i] <= m4[i];
      sum5  <= LEN_W'(sq4[0]) + LEN_W'(sq4[1]) + LEN_W'(sq4[2]) + LEN_W'(sq4[3]);
    end
  end

  lao_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (RAD_W'(sum5)),
    .root (root)
  );

  // carry the item alongside the root
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQRT_LAT; i++) sdly[i].vld <= 1'b0;
    end else if (en) begin
      sdly[0] <= '{vld: v5, sgn: sgn5, mag: m5, side: side5};
      for (int i = 1; i < SQRT_LAT; i++) sdly[i] <= sdly[i-1];
    end
  end

  // stage 6: rounded dividends v * 2^14 + root / 2
  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6    <= sdly[SQRT_LAT-1].vld;
      sgn6  <= sdly[SQRT_LAT-1].sgn;
      side6 <= sdly[SQRT_LAT-1].side;
      den6  <= root[DIV_DEN_W-1:0];
      for (int i = 0; i < 4; i++) begin
        num6[i] <= DIV_NUM_W'({sdly[SQRT_LAT-1].mag[i], 14'b0}) + DIV_NUM_W'(root >> 1);
      end
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_div
    lao_div u_div (
      .clk (clk),
      .en  (en),
      .num (num6[g]),
      .den (den6),
      .quo (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) ddly[i].vld <= 1'b0;
    end else if (en) begin
      ddly[0] <= '{vld: v6, sgn: sgn6, side: side6};
      for (int i = 1; i < DIV_LAT; i++) ddly[i] <= ddly[i-1];
    end
  end

  // stage 7: clamp and restore sign
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      clm[i] = (quo[i] > DIV_QUO_W'(ONE)) ? 15'(ONE) : quo[i][14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ddly[DIV_LAT-1].vld;
      out_side  <= ddly[DIV_LAT-1].side;
      for (int i = 0; i < 4; i++) begin
        unit[i] <= ddly[DIV_LAT-1].sgn[i] ? -16'(clm[i]) : 16'(clm[i]);
      end
    end
  end

endmodule

// ----- rtl/core/lao_cross.sv -----
module lao_cross (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  lao_pkg::vec3_t              a,
  input  lao_pkg::vec3_t              b,
  input  lao_pkg::vec3_t              b_alt,
  input  logic                        alt_en,
  input  logic [lao_pkg::LEN_W-1:0]   eps,
  input  lao_pkg::vec3_t              fallback,
  input  lao_pkg::pipe_t              in_side,
  output logic                        out_valid,
  output lao_pkg::nval_t              vec [4],
  output lao_pkg::pipe_t              out_side
);
  import lao_pkg::*;

  logic               v1, v2, v3;
  pipe_t              side1, side2, side3;
  pipe_t              side_o;
  logic signed [31:0] p1 [6];
  logic signed [31:0] pa1 [6];
  logic signed [31:0] c2 [3];
  logic signed [31:0] ca2 [3];
  logic signed [31:0] c3 [3];
  logic signed [31:0] ca3 [3];
  logic signed [63:0] sqp [3];
  logic signed [63:0] sqa [3];
  logic [LEN_W-1:0]   sq3 [3];
  logic [LEN_W-1:0]   sqa3 [3];
  logic [LEN_W-1:0]   len, lena;
  logic               short_p, short_a, use_alt;

  // stage 1: the six products of each cross product
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1     <= in_valid;
      side1  <= in_side;
      p1[0]  <= a.y * b.z;
      p1[1]  <= a.z * b.y;
      p1[2]  <= a.z * b.x;
      p1[3]  <= a.x * b.z;
      p1[4]  <= a.x * b.y;
      p1[5]  <= a.y * b.x;
      pa1[0] <= a.y * b_alt.z;
      pa1[1] <= a.z * b_alt.y;
      pa1[2] <= a.z * b_alt.x;
      pa1[3] <= a.x * b_alt.z;
      pa1[4] <= a.x * b_alt.y;
      pa1[5] <= a.y * b_alt.x;
    end
  end

  // stage 2: differences
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2    <= v1;
      side2 <= side1;
      for (int j = 0; j < 3; j++) begin
        c2[j]  <= p1[2*j] - p1[2*j+1];
        ca2[j] <= pa1[2*j] - pa1[2*j+1];
      end
    end
  end

  // stage 3: squares
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      sqp[j] = c2[j] * c2[j];
      sqa[j] = ca2[j] * ca2[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3    <= v2;
      side3 <= side2;
      c3    <= c2;
      ca3   <= ca2;
      for (int j = 0; j < 3; j++) begin
        sq3[j]  <= sqp[j][LEN_W-1:0];
        sqa3[j] <= sqa[j][LEN_W-1:0];
      end
    end
  end

  // stage 4: length tests and choice of vector
  always_comb begin
    len     = sq3[0] + sq3[1] + sq3[2];
    lena    = sqa3[0] + sqa3[1] + sqa3[2];
    short_p = len <= eps;
    short_a = lena <= eps;
    use_alt = alt_en && short_p;
    side_o  = side3;
    if (alt_en) side_o.backup = use_alt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid       <= v3;
      out_side        <= side_o;
      vec[3]          <= '0;
      if (use_alt ? short_a : short_p) begin
        vec[0] <= NW'(fallback.x);
        vec[1] <= NW'(fallback.y);
        vec[2] <= NW'(fallback.z);
      end else begin
        for (int j = 0; j < 3; j++) vec[j] <= NW'(use_alt ? ca3[j] : c3[j]);
      end
    end
  end

endmodule

// ----- rtl/core/lao_quat.sv -----
module lao_quat (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  lao_pkg::pipe_t   in_side,
  output logic             out_valid,
  output lao_pkg::nval_t   q [4],
  output lao_pkg::pipe_t   out_side
);
  import lao_pkg::*;

  typedef logic signed [16:0] mel_t;
  typedef logic signed [17:0] num_t;

  typedef struct packed {
    logic                vld;
    logic                pos;
    logic [1:0]          a;
    logic [2:0][17:0]    n;
    pipe_t               side;
  } sq_dly_t;

  typedef struct packed {
    logic         vld;
    logic         pos;
    logic [1:0]   a;
    logic [2:0]   sgn;
    logic [28:0]  main;
    pipe_t        side;
  } dv_dly_t;

  logic              v1, v2, v3;
  pipe_t             side1, side2, side3;
  mel_t              m1 [3][3];
  logic signed [17:0] tr1;
  logic              pos, pos2, pos3;
  logic [1:0]        a, b, k, a2, a3;
  logic signed [18:0] argn;
  logic [16:0]       arg, arg2;
  num_t              n [3];
  logic [2:0][17:0]  n2;
  logic [ROOT_W-1:0] root;
  sq_dly_t           sdly [SQRT_LAT];
  num_t              nd;
  logic [15:0]       nmag [3];
  logic [DIV_NUM_W-1:0] num3 [3];
  logic [DIV_DEN_W-1:0] den3;
  logic [2:0]        sgn3;
  logic [28:0]       main3;
  logic [DIV_QUO_W-1:0] quo [3];
  dv_dly_t           ddly [DIV_LAT];
  nval_t             d [3];
  nval_t             qa [4];
  logic [1:0]        ab, ak;

  // stage 1: matrix with columns right, up, -forward, and its trace
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1       <= in_valid;
      side1    <= in_side;
      m1[0][0] <= mel_t'(in_side.r.x);
      m1[1][0] <= mel_t'(in_side.r.y);
      m1[2][0] <= mel_t'(in_side.r.z);
      m1[0][1] <= mel_t'(in_side.u.x);
      m1[1][1] <= mel_t'(in_side.u.y);
      m1[2][1] <= mel_t'(in_side.u.z);
      m1[0][2] <= -mel_t'(in_side.f.x);
      m1[1][2] <= -mel_t'(in_side.f.y);
      m1[2][2] <= -mel_t'(in_side.f.z);
      tr1      <= 18'(in_side.r.x) + 18'(in_side.u.y) - 18'(in_side.f.z);
    end
  end

  // stage 2: branch, root argument and the three numerators
  always_comb begin
    pos = tr1 > 0;
    a   = 2'd0;
    if (m1[1][1] > m1[0][0]) a = 2'd1;
    if (m1[2][2] > m1[a][a]) a = 2'd2;
    b    = (a == 2'd2) ? 2'd0 : a + 2'd1;
    k    = (b == 2'd2) ? 2'd0 : b + 2'd1;
    argn = 19'(m1[a][a]) - 19'(m1[b][b]) - 19'(m1[k][k]) + 19'(ONE);
    if (pos) begin
      arg  = 17'(tr1 + 18'(ONE));
      n[0] = num_t'(m1[2][1]) - num_t'(m1[1][2]);
      n[1] = num_t'(m1[0][2]) - num_t'(m1[2][0]);
      n[2] = num_t'(m1[1][0]) - num_t'(m1[0][1]);
    end else begin
      arg  = (argn < 19'sd1) ? 17'd1 : argn[16:0];
      n[0] = num_t'(m1[a][b]) + num_t'(m1[b][a]);
      n[1] = num_t'(m1[a][k]) + num_t'(m1[k][a]);
      n[2] = num_t'(m1[k][b]) - num_t'(m1[b][k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2    <= v1;
      side2 <= side1;
      pos2  <= pos;
      a2    <= a;
      arg2  <= arg;
      for (int j = 0; j < 3; j++) n2[j] <= n[j];
    end
  end

  lao_isqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (RAD_W'({arg2, 42'b0})),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SQRT_LAT; i++) sdly[i].vld <= 1'b0;
    end else if (en) begin
      sdly[0] <= '{vld: v2, pos: pos2, a: a2, n: n2, side: side2};
      for (int i = 1; i < SQRT_LAT; i++) sdly[i] <= sdly[i-1];
    end
  end

  // stage 3: dividends |n| * 2^42 + root over 2 * root
  always_comb begin
    nd = '0;
    for (int j = 0; j < 3; j++) begin
      nd      = num_t'(sdly[SQRT_LAT-1].n[j]);
      nmag[j] = nd[17] ? 16'(-nd) : 16'(nd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3    <= sdly[SQRT_LAT-1].vld;
      side3 <= sdly[SQRT_LAT-1].side;
      pos3  <= sdly[SQRT_LAT-1].pos;
      a3    <= sdly[SQRT_LAT-1].a;
      main3 <= root[29:1];
      den3  <= {root[29:0], 1'b0};
      for (int j = 0; j < 3; j++) begin
        sgn3[j] <= sdly[SQRT_LAT-1].n[j][17];
        num3[j] <= DIV_NUM_W'({nmag[j], 42'b0}) + DIV_NUM_W'(root);
      end
    end
  end

  for (genvar g = 0; g < 3; g++) begin : g_div
    lao_div u_div (
      .clk (clk),
      .en  (en),
      .num (num3[g]),
      .den (den3),
      .quo (quo[g])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DIV_LAT; i++) ddly[i].vld <= 1'b0;
    end else if (en) begin
      ddly[0] <= '{vld: v3, pos: pos3, a: a3, sgn: sgn3, main: main3, side: side3};
      for (int i = 1; i < DIV_LAT; i++) ddly[i] <= ddly[i-1];
    end
  end

  // stage 4: signs, placement of terms, null fallback
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d[j] = ddly[DIV_LAT-1].sgn[j] ? -NW'({2'b0, quo[j]}) : NW'({2'b0, quo[j]});
    end
    ab = (ddly[DIV_LAT-1].a == 2'd2) ? 2'd0 : ddly[DIV_LAT-1].a + 2'd1;
    ak = (ab == 2'd2) ? 2'd0 : ab + 2'd1;
    if (ddly[DIV_LAT-1].pos) begin
      qa[0] = NW'(ddly[DIV_LAT-1].main);
      qa[1] = d[0];
      qa[2] = d[1];
      qa[3] = d[2];
    end else begin
      qa[0] = d[2];
      qa[1] = '0;
      qa[2] = '0;
      qa[3] = '0;
      qa[ddly[DIV_LAT-1].a + 2'd1] = NW'(ddly[DIV_LAT-1].main);
      qa[ab + 2'd1] = d[0];
      qa[ak + 2'd1] = d[1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= ddly[DIV_LAT-1].vld;
      out_side  <= ddly[DIV_LAT-1].side;
      if (qa[0] == '0 && qa[1] == '0 && qa[2] == '0 && qa[3] == '0) begin
        q[0] <= NW'(1);
        q[1] <= '0;
        q[2] <= '0;
        q[3] <= '0;
      end else begin
        q <= qa;
      end
    end
  end

endmodule

// ----- rtl/core/look_at_orientation_quaternion.sv -----
// channel   dir  beat fields (tdata/tuser, low bit up)
// s_axis    in   tdata: forward xyz, up_hint xyz, backup_up xyz (9 x 16 bit)
// m_axis    out  tdata: quat w, x, y, z (4 x 16 bit); tuser: used_backup_up
//
// One beat per cycle sustained while m_axis accepts beats. The latency lies mostly
// in the four vector normalizers and the trace solver, each
// built around a 32-stage square root and a 36-stage divider.
// rst is synchronous; it clears every valid bit and holds s_axis_tready low.
// A stall on m_axis freezes the whole pipe in place; s_axis_tready drops with it.
module look_at_orientation_quaternion (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [143:0]  s_axis_tdata,   // fwd x,y,z, up_hint x,y,z, backup_up x,y,z
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [63:0]   m_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
  output logic [0:0]    m_axis_tuser    // used_backup_up
);
  import lao_pkg::*;

  logic   en;
  logic   v0;
  vec3_t  fr0, hp0, hb0;
  pipe_t  side0;
  nval_t  n1_vec [4];
  logic   n1_valid, c1_valid, n2_valid, c2_valid, n3_valid, qs_valid, n4_valid;
  q14_t   n1_unit [4];
  q14_t   n2_unit [4];
  q14_t   n3_unit [4];
  q14_t   n4_unit [4];
  pipe_t  n1_side, c1_in, c1_side, n2_side, c2_in, c2_side, n3_side, qs_in;
  pipe_t  qs_side, n4_side;
  nval_t  c1_vec [4];
  nval_t  c2_vec [4];
  nval_t  qs_vec [4];

  // whole pipe advances unless the output beat is held
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en && !rst;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0    <= s_axis_tvalid;
      fr0.x <= s_axis_tdata[15:0];
      fr0.y <= s_axis_tdata[31:16];
      fr0.z <= s_axis_tdata[47:32];
      hp0.x <= s_axis_tdata[63:48];
      hp0.y <= s_axis_tdata[79:64];
      hp0.z <= s_axis_tdata[95:80];
      hb0.x <= s_axis_tdata[111:96];
      hb0.y <= s_axis_tdata[127:112];
      hb0.z <= s_axis_tdata[143:128];
    end
  end

  // zero forward becomes (0,0,-1)
  always_comb begin
    side0        = '0;
    side0.hp     = hp0;
    side0.hb     = hb0;
    if (fr0 == '0) begin
      n1_vec[0] = '0;
      n1_vec[1] = '0;
      n1_vec[2] = -NW'(1);
    end else begin
      n1_vec[0] = NW'(fr0.x);
      n1_vec[1] = NW'(fr0.y);
      n1_vec[2] = NW'(fr0.z);
    end
    n1_vec[3] = '0;
  end

  lao_norm u_norm_fwd (
    .clk (clk), .rst (rst), .en (en),
    .in_valid (v0), .vec (n1_vec), .in_side (side0),
    .out_valid (n1_valid), .unit (n1_unit), .out_side (n1_side)
  );

  always_comb begin
    c1_in     = n1_side;
    c1_in.f.x = n1_unit[0];
    c1_in.f.y = n1_unit[1];
    c1_in.f.z = n1_unit[2];
  end

  // right = forward x hint, backup hint, then (1,0,0)
  lao_cross u_cross_right (
    .clk (clk), .rst (rst), .en (en), .in_valid (n1_valid),
    .a (c1_in.f), .b (c1_in.hp), .b_alt (c1_in.hb), .alt_en (1'b1),
    .eps (EPS_RIGHT), .fallback ('{x: 16'sd1, y: 16'sd0, z: 16'sd0}),
    .in_side (c1_in),
    .out_valid (c1_valid), .vec (c1_vec), .out_side (c1_side)
  );

  lao_norm u_norm_right (
    .clk (clk), .rst (rst), .en (en),
    .in_valid (c1_valid), .vec (c1_vec), .in_side (c1_side),
    .out_valid (n2_valid), .unit (n2_unit), .out_side (n2_side)
  );

  always_comb begin
    c2_in     = n2_side;
    c2_in.r.x = n2_unit[0];
    c2_in.r.y = n2_unit[1];
    c2_in.r.z = n2_unit[2];
  end

  // up = right x forward, or (0,1,0)
  lao_cross u_cross_up (
    .clk (clk), .rst (rst), .en (en), .in_valid (n2_valid),
    .a (c2_in.r), .b (c2_in.f), .b_alt (c2_in.f), .alt_en (1'b0),
    .eps (EPS_UP), .fallback ('{x: 16'sd0, y: 16'sd1, z: 16'sd0}),
    .in_side (c2_in),
    .out_valid (c2_valid), .vec (c2_vec), .out_side (c2_side)
  );

  lao_norm u_norm_up (
    .clk (clk), .rst (rst), .en (en),
    .in_valid (c2_valid), .vec (c2_vec), .in_side (c2_side),
    .out_valid (n3_valid), .unit (n3_unit), .out_side (n3_side)
  );

  always_comb begin
    qs_in     = n3_side;
    qs_in.u.x = n3_unit[0];
    qs_in.u.y = n3_unit[1];
    qs_in.u.z = n3_unit[2];
  end

  lao_quat u_quat (
    .clk (clk), .rst (rst), .en (en), .in_valid (n3_valid), .in_side (qs_in),
    .out_valid (qs_valid), .q (qs_vec), .out_side (qs_side)
  );

  lao_norm u_norm_quat (
    .clk (clk), .rst (rst), .en (en),
    .in_valid (qs_valid), .vec (qs_vec), .in_side (qs_side),
    .out_valid (n4_valid), .unit (n4_unit), .out_side (n4_side)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= n4_valid;
      m_axis_tdata  <= {n4_unit[3], n4_unit[2], n4_unit[1], n4_unit[0]};
      m_axis_tuser  <= n4_side.backup;
    end
  end

endmodule

// ----- rtl/core/lao_check.sv -----
module lao_check (
  input logic          clk,
  input logic          rst,
  input logic          s_axis_tready,
  input logic          m_axis_tvalid,
  input logic          m_axis_tready,
  input logic [63:0]   m_axis_tdata,
  input logic [0:0]    m_axis_tuser
);

  // nothing comes out right after reset
  a_rst_quiet: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output beat right after reset");

  // a held output beat keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser))
    else $error("held output beat changed");

  // input side stalls while an output beat waits
  a_back: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken during output stall");

  // quaternion components stay within one
  a_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      $signed(m_axis_tdata[15:0]) >= -16'sd16384 && $signed(m_axis_tdata[15:0]) <= 16'sd16384 &&
      $signed(m_axis_tdata[31:16]) >= -16'sd16384 && $signed(m_axis_tdata[31:16]) <= 16'sd16384 &&
      $signed(m_axis_tdata[47:32]) >= -16'sd16384 && $signed(m_axis_tdata[47:32]) <= 16'sd16384 &&
      $signed(m_axis_tdata[63:48]) >= -16'sd16384 && $signed(m_axis_tdata[63:48]) <= 16'sd16384)
    else $error("quaternion component out of range");

endmodule

bind look_at_orientation_quaternion lao_check u_check (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
